// ===== hdl/kxy_pkg.sv =====
`default_nettype none
package kxy_pkg;

	localparam int POS_FRAC_BITS_DEF = 8;

	localparam int POS_W   = 24;
	localparam int COEF_W  = 16;
	localparam int NOISE_W = 24;
	localparam int COV_W   = 32;
	localparam int GAIN_W  = 18;
	localparam int NUM_W   = 52;
	localparam int DEN_W   = 41;
	localparam int QUO_W   = 19;

	localparam logic signed [15:0] TRANS_RST = 16'sd4096;
	localparam logic signed [15:0] OBS_RST   = 16'sd4096;
	localparam logic [23:0]        QN_RST    = 24'd6554;
	localparam logic [23:0]        RN_RST    = 24'd6554;
	localparam logic [31:0]        COV_RST   = 32'd65536;

	typedef enum logic [1:0] {
		REG_TRANS_GAIN    = 2'd0,
		REG_OBS_GAIN      = 2'd1,
		REG_PROCESS_NOISE = 2'd2,
		REG_MEASURE_NOISE = 2'd3
	} kxy_reg_t;

	// Step strobes for both position lanes; the top gives the y lane its own keep.
	typedef struct packed {
		logic load;
		logic pred_mul;
		logic pred_rnd;
		logic obs_mul;
		logic innov;
		logic corr_mul;
		logic corr_add;
		logic commit;
		logic keep;
	} kxy_lane_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/kxy_lane.sv =====
`default_nettype none
module kxy_lane
	import kxy_pkg::*;
#(
	parameter int FRAC_BITS = POS_FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire kxy_lane_ctl_t       ctl,
	input  wire logic signed [15:0]  a,
	input  wire logic signed [15:0]  h,
	input  wire logic signed [17:0]  g,
	input  wire logic signed [23:0]  z,
	output logic signed [23:0]       est_next
);

	localparam logic signed [23:0] EST_RST = 24'sd1 <<< FRAC_BITS;

	function automatic logic signed [23:0] sat24(input logic signed [32:0] v);
		logic signed [23:0] r;
		if (v > 33'sd8388607) begin
			r = 24'sh7fffff;
		end else if (v < -33'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	logic signed [23:0] est_q, z_q, xp_q, nx_q;
	logic signed [39:0] prod_q, hx_q;
	logic signed [28:0] inn_q;
	logic signed [46:0] m_q;

	logic signed [40:0] prod_r, hx_r;
	logic signed [47:0] m_r;
	logic signed [31:0] cor;
	logic signed [32:0] sum;

	always_comb begin
		prod_r = {prod_q[39], prod_q} + 41'sd2048;
		hx_r   = {hx_q[39], hx_q} + 41'sd2048;
		m_r    = {m_q[46], m_q} + 48'sd32768;
		cor    = $signed(m_r[47:16]);
		sum    = 33'(xp_q) + 33'(cor);
	end

	assign est_next = ctl.keep ? est_q : nx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= EST_RST;
		end else if (ctl.commit) begin
			est_q <= est_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load)     z_q    <= z;
		if (ctl.pred_mul) prod_q <= a * est_q;
		if (ctl.pred_rnd) xp_q   <= sat24(33'($signed(prod_r[40:12])));
		if (ctl.obs_mul)  hx_q   <= h * xp_q;
		if (ctl.innov)    inn_q  <= 29'(z_q) - $signed(hx_r[40:12]);
		if (ctl.corr_mul) m_q    <= g * inn_q;
		if (ctl.corr_add) nx_q   <= sat24(sum);
	end

endmodule
`default_nettype wire

// ===== hdl/kxy_gain.sv =====
`default_nettype none
module kxy_gain
	import kxy_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NUM_W-1:0]     num,
	input  wire logic [DEN_W-1:0]     den,
	input  wire logic                 neg,
	output logic                      done,
	output logic signed [17:0]        g,
	output logic                      fault
);

	// Restoring division, one quotient bit per cycle. A quotient that would
	// not fit in QUO_W bits is caught up front and saturates.
	localparam int DIV_W = DEN_W + QUO_W - 1;

	logic [NUM_W-1:0] num_q, rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DIV_W-1:0] d_q;
	logic [QUO_W-1:0] q_q, qc;
	logic [4:0]       cnt_q;
	logic             neg_q, chk_q, it_q, done_q, fault_q, ge;

	assign ge = {{(DIV_W-NUM_W){1'b0}}, rem_q} >= d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q  <= 1'b0;
			it_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				chk_q <= 1'b1;
				it_q  <= 1'b0;
			end else if (chk_q) begin
				chk_q <= 1'b0;
				if (den_q == '0 ||
					{8'b0, num_q} >= {den_q, {QUO_W{1'b0}}}) begin
					done_q <= 1'b1;
				end else begin
					it_q <= 1'b1;
				end
			end else if (it_q && cnt_q == '0) begin
				it_q   <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			neg_q <= neg;
		end else if (chk_q) begin
			fault_q <= (den_q == '0);
			rem_q   <= num_q;
			d_q     <= {den_q, {(QUO_W-1){1'b0}}};
			cnt_q   <= 5'(QUO_W - 1);
			if (den_q == '0) begin
				q_q <= '0;
			end else if ({8'b0, num_q} >= {den_q, {QUO_W{1'b0}}}) begin
				q_q <= '1;
			end else begin
				q_q <= '0;
			end
		end else if (it_q) begin
			if (ge) rem_q <= rem_q - d_q[NUM_W-1:0];
			q_q   <= {q_q[QUO_W-2:0], ge};
			d_q   <= d_q >> 1;
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_comb begin
		if (neg_q) begin
			qc = (q_q > 19'd131072) ? 19'd131072 : q_q;
			g  = -$signed(qc[17:0]);
		end else begin
			qc = (q_q > 19'd131071) ? 19'd131071 : q_q;
			g  = $signed(qc[17:0]);
		end
	end

	assign done  = done_q;
	assign fault = fault_q;

endmodule
`default_nettype wire

// ===== hdl/kxy_merge.sv =====
`default_nettype none
module kxy_merge
	import kxy_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire logic signed [23:0]  new_x,
	input  wire logic signed [23:0]  new_y,
	input  wire logic [31:0]         new_cov,
	input  wire logic signed [17:0]  new_gain,
	input  wire logic                new_fault,
	output logic                     ready,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [23:0]       est_x,
	output logic signed [23:0]       est_y,
	output logic [31:0]              covariance,
	output logic signed [17:0]       gain,
	output logic                     div_fault
);

	logic valid_q;

	assign ready     = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			est_x      <= new_x;
			est_y      <= new_y;
			covariance <= new_cov;
			gain       <= new_gain;
			div_fault  <= new_fault;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/scalar_kalman_xy_tracker.sv =====
// Scalar Kalman tracker for an x,y position, one request at a time.
// The gain divider (19 quotient bits, one per cycle, plus a check step) sets most
// of the delay from an accepted input request to out_valid.
// A zero denominator or a saturated gain skips the divider loop.
// A new request is accepted the cycle after the result enters the output
// register; a held out_stall can delay that entry, and no two requests overlap.
// Reset (arst_n low) restores config, state, both estimates to 1.0 and P to 1.0.
`default_nettype none
module scalar_kalman_xy_tracker
	import kxy_pkg::*;
#(
	parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [23:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                mode,
	input  wire logic signed [23:0]  pos_x,
	input  wire logic signed [23:0]  pos_y,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [23:0]       est_x,
	output logic signed [23:0]       est_y,
	output logic [31:0]              covariance,
	output logic signed [17:0]       gain,
	output logic                     div_fault
);

	// Sequencer states. The two lanes follow the same strobes but for keep, while the
	// shared covariance and gain path lives here.
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_SQ   = 8'b0000_0010,
		ST_PP   = 8'b0000_0100,
		ST_DEN  = 8'b0000_1000,
		ST_DIV  = 8'b0001_0000,
		ST_MUL  = 8'b0010_0000,
		ST_ADD  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} kxy_state_t;

	kxy_state_t state_q, state_d;

	logic signed [15:0] a_q, h_q;
	logic [23:0]        qn_q, rn_q;
	logic [31:0]        cov_q, pp_q;
	logic [30:0]        a2_q, h2_q;
	logic               mode_q;
	logic signed [22:0] gh_q;
	logic signed [40:0] corr_q;

	logic               in_acc, commit, merge_ready, div_done, div_fault_w;
	logic signed [17:0] g_w;
	logic signed [31:0] a_sq, h_sq;
	logic [62:0]        pp_prod, den_prod;
	logic [63:0]        pp_r, den_r;
	logic [40:0]        pp_sum;
	logic [31:0]        pp_d;
	logic [DEN_W-1:0]   den_w;
	logic [16:0]        h_abs;
	logic [NUM_W-1:0]   num_w;
	logic signed [33:0] gh_prod;
	logic signed [34:0] gh_r;
	logic signed [55:0] corr_prod;
	logic signed [56:0] corr_r;
	logic signed [41:0] pn;
	logic [31:0]        pn_sat;
	logic signed [23:0] nx_x, nx_y;
	kxy_lane_ctl_t      ctl_x, ctl_y;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  <= TRANS_RST;
			h_q  <= OBS_RST;
			qn_q <= QN_RST;
			rn_q <= RN_RST;
		end else if (cfg_valid) begin
			unique case (kxy_reg_t'(cfg_index))
				REG_TRANS_GAIN:    a_q  <= $signed(cfg_data[15:0]);
				REG_OBS_GAIN:      h_q  <= $signed(cfg_data[15:0]);
				REG_PROCESS_NOISE: qn_q <= cfg_data;
				REG_MEASURE_NOISE: rn_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign commit   = (state_q == ST_FIN) && merge_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_SQ;
			ST_SQ:   state_d = ST_PP;
			ST_PP:   state_d = ST_DEN;
			ST_DEN:  state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_MUL;
			ST_MUL:  state_d = ST_ADD;
			ST_ADD:  state_d = ST_FIN;
			ST_FIN:  if (merge_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cov_q   <= COV_RST;
		end else begin
			state_q <= state_d;
			if (commit) cov_q <= pn_sat;
		end
	end

	// Predicted covariance: A*A*P rescaled with rounding, plus Q, saturated.
	always_comb begin
		a_sq     = a_q * a_q;
		h_sq     = h_q * h_q;
		pp_prod  = a2_q * cov_q;
		pp_r     = {1'b0, pp_prod} + 64'd8388608;
		pp_sum   = {1'b0, pp_r[63:24]} + {17'b0, qn_q};
		pp_d     = (pp_sum > 41'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : pp_sum[31:0];
		// Gain numerator and denominator come from the same predicted P.
		den_prod = h2_q * pp_q;
		den_r    = {1'b0, den_prod} + 64'd8388608;
		den_w    = {1'b0, den_r[63:24]} + {17'b0, rn_q};
		h_abs    = h_q[15] ? -{h_q[15], h_q} : {h_q[15], h_q};
		num_w    = {48'(pp_q) * 48'(h_abs[15:0]), 4'b0};
		// Covariance correction: P - round(round(g*H)*P).
		gh_prod   = g_w * h_q;
		gh_r      = {gh_prod[33], gh_prod} + 35'sd2048;
		corr_prod = gh_q * $signed({1'b0, pp_q});
		corr_r    = {corr_prod[55], corr_prod} + 57'sd32768;
		pn        = $signed({10'b0, pp_q}) - 42'(corr_q);
		if (pn < 0) begin
			pn_sat = '0;
		end else if (pn > 42'sh0_FFFF_FFFF) begin
			pn_sat = 32'hFFFF_FFFF;
		end else begin
			pn_sat = pn[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) mode_q <= mode;
		if (state_q == ST_SQ) begin
			a2_q <= a_sq[30:0];
			h2_q <= h_sq[30:0];
		end
		if (state_q == ST_PP)  pp_q   <= pp_d;
		if (state_q == ST_MUL) gh_q   <= $signed(gh_r[34:12]);
		if (state_q == ST_ADD) corr_q <= $signed(corr_r[56:16]);
	end

	kxy_gain u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DEN),
		.num    (num_w),
		.den    (den_w),
		.neg    (h_q[15]),
		.done   (div_done),
		.g      (g_w),
		.fault  (div_fault_w)
	);

	always_comb begin
		ctl_x.load     = in_acc;
		ctl_x.pred_mul = (state_q == ST_SQ);
		ctl_x.pred_rnd = (state_q == ST_PP);
		ctl_x.obs_mul  = (state_q == ST_DEN);
		ctl_x.innov    = (state_q == ST_DIV);
		ctl_x.corr_mul = (state_q == ST_MUL);
		ctl_x.corr_add = (state_q == ST_ADD);
		ctl_x.commit   = commit;
		ctl_x.keep     = 1'b0;
		ctl_y          = ctl_x;
		// In x-only mode the y lane keeps its old estimate.
		ctl_y.keep     = mode_q;
	end

	kxy_lane #(.FRAC_BITS(POS_FRAC_BITS)) u_lane_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_x),
		.a        (a_q),
		.h        (h_q),
		.g        (g_w),
		.z        (pos_x),
		.est_next (nx_x)
	);

	kxy_lane #(.FRAC_BITS(POS_FRAC_BITS)) u_lane_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_y),
		.a        (a_q),
		.h        (h_q),
		.g        (g_w),
		.z        (pos_y),
		.est_next (nx_y)
	);

	kxy_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (commit),
		.new_x      (nx_x),
		.new_y      (nx_y),
		.new_cov    (pn_sat),
		.new_gain   (g_w),
		.new_fault  (div_fault_w),
		.ready      (merge_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.est_x      (est_x),
		.est_y      (est_y),
		.covariance (covariance),
		.gain       (gain),
		.div_fault  (div_fault)
	);

endmodule
`default_nettype wire

// ===== dv/scalar_kalman_xy_tracker_tb.sv =====
`default_nettype none
module scalar_kalman_xy_tracker_tb;
	import kxy_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// One filter result as it leaves the block.
	typedef struct packed {
		logic signed [23:0] est_x;
		logic signed [23:0] est_y;
		logic [31:0]        covariance;
		logic signed [17:0] gain;
		logic               div_fault;
	} track_result_t;

	// The tracker predictor together with the queue of results it has worked out.
	class track_scoreboard;
		longint        a_coef, h_coef;
		longint        q_noise, r_noise;
		longint        x_est, y_est;
		longint        p_cov;
		track_result_t pending[$];
		int            errors;
		int            checked;
		int            faults;

		function new();
			a_coef = 4096;
			h_coef = 4096;
			q_noise = 6554;
			r_noise = 6554;
			x_est = 256;
			y_est = 256;
			p_cov = 65536;
			errors = 0;
			checked = 0;
			faults = 0;
		endfunction

		function void set_reg(kxy_reg_t idx, logic [23:0] value);
			case (idx)
				REG_TRANS_GAIN: begin
					a_coef = longint'($signed(value[15:0]));
				end
				REG_OBS_GAIN: begin
					h_coef = longint'($signed(value[15:0]));
				end
				REG_PROCESS_NOISE: begin
					q_noise = longint'(value);
				end
				REG_MEASURE_NOISE: begin
					r_noise = longint'(value);
				end
			endcase
		endfunction

		// Shift right by s with the half rounded up (toward plus infinity).
		function longint round_shift(longint v, int s);
			longint t;
			t = v + (longint'(1) <<< (s - 1));
			return t >>> s;
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -(longint'(1) <<< (w - 1));
			if (v > hi) begin
				return hi;
			end
			if (v < lo) begin
				return lo;
			end
			return v;
		endfunction

		// Note an accepted measurement and queue the result it must produce.
		function void note_request(logic x_only, logic signed [23:0] zx_in,
				logic signed [23:0] zy_in);
			longint        zx, zy, xp, yp, g, gh, corr, pn;
			longint unsigned a2, h2, pp, den, ah, q;
			track_result_t r;
			zx = zx_in;
			zy = zy_in;
			a2 = longint'(a_coef * a_coef);
			h2 = longint'(h_coef * h_coef);
			xp = clamp(round_shift(a_coef * x_est, 12), 24);
			yp = clamp(round_shift(a_coef * y_est, 12), 24);
			pp = ((a2 * longint'(p_cov) + (64'd1 << 23)) >> 24) + q_noise;
			if (pp > 64'hFFFF_FFFF) begin
				pp = 64'hFFFF_FFFF;
			end
			den = ((h2 * pp + (64'd1 << 23)) >> 24) + r_noise;
			g = 0;
			r.div_fault = 1'b0;
			if (den == 0) begin
				r.div_fault = 1'b1;
				faults++;
			end else begin
				ah = (h_coef < 0) ? -h_coef : h_coef;
				q = ((pp * ah) << 4) / den;
				if (h_coef < 0) begin
					if (q > 131072) begin
						q = 131072;
					end
					g = -longint'(q);
				end else begin
					if (q > 131071) begin
						q = 131071;
					end
					g = q;
				end
			end
			x_est = clamp(xp + round_shift(g * (zx - round_shift(h_coef * xp, 12)), 16), 24);
			if (!x_only) begin
				y_est = clamp(yp + round_shift(g * (zy - round_shift(h_coef * yp, 12)), 16), 24);
			end
			gh = round_shift(g * h_coef, 12);
			corr = round_shift(gh * longint'(pp), 16);
			pn = longint'(pp) - corr;
			if (pn < 0) begin
				pn = 0;
			end
			if (pn > 64'sh0_FFFF_FFFF) begin
				pn = 64'sh0_FFFF_FFFF;
			end
			p_cov = pn;
			r.est_x = x_est[23:0];
			r.est_y = y_est[23:0];
			r.covariance = p_cov[31:0];
			r.gain = g[17:0];
			pending.push_back(r);
		endfunction

		// Compare one result from the block with the oldest expectation.
		function void check_result(track_result_t got);
			track_result_t exp_r;
			if (pending.size() == 0) begin
				report("result with nothing expected", 0, 0);
				return;
			end
			exp_r = pending.pop_front();
			checked++;
			if (got.est_x !== exp_r.est_x) begin
				report("est_x", got.est_x, exp_r.est_x);
			end
			if (got.est_y !== exp_r.est_y) begin
				report("est_y", got.est_y, exp_r.est_y);
			end
			if (got.covariance !== exp_r.covariance) begin
				report("covariance", got.covariance, exp_r.covariance);
			end
			if (got.gain !== exp_r.gain) begin
				report("gain", got.gain, exp_r.gain);
			end
			if (got.div_fault !== exp_r.div_fault) begin
				report("div_fault", got.div_fault, exp_r.div_fault);
			end
		endfunction

		// One line per mismatch for the first 40; the total decides the verdict at the end.
		function void report(string what, longint got, longint want);
			errors++;
			if (errors <= 40) begin
				$display("MISMATCH %s at result %0d: got 0x%0h expected 0x%0h",
					what, checked, got, want);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [23:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               mode = 1'b0;
	logic signed [23:0] pos_x = '0;
	logic signed [23:0] pos_y = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [23:0] est_x;
	logic signed [23:0] est_y;
	logic [31:0]        covariance;
	logic signed [17:0] gain;
	logic               div_fault;

	track_scoreboard tracker = new();
	int              idle_cycles = 0;
	int              sent = 0;
	int              stall_style = 0;
	// Longest run of cycles with no handshake on any channel that the watchdog
	// allows before it ends the run as failed.
	localparam int   HANG_LIMIT = 4000;

	always #4 clk = ~clk;

	scalar_kalman_xy_tracker u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.est_x      (est_x),
		.est_y      (est_y),
		.covariance (covariance),
		.gain       (gain),
		.div_fault  (div_fault)
	);

	// Results are taken at the rising edge, where valid is high and stall low.
	// The watchdog counts rising edges on which no channel moves anything.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				tracker.check_result('{est_x, est_y, covariance, gain, div_fault});
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= HANG_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", HANG_LIMIT);
				$display("scalar_kalman_xy_tracker_tb failed");
				$finish;
			end
		end
	end

	// The receiver stalls on a pattern of its own, changed from phase to phase:
	// none at all, light random, heavy random, or random at 20 in 64.
	always @(negedge clk) begin
		case (stall_style)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				out_stall <= (($urandom_range(0, 63) < 20) ? 1'b1 : 1'b0);
			end
		endcase
	end

	// Write one register while the block is idle; the model follows at once.
	task automatic write_reg(kxy_reg_t idx, logic [23:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		tracker.set_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(logic [15:0] a, logic [15:0] h, logic [23:0] q,
			logic [23:0] r);
		write_reg(REG_TRANS_GAIN, {8'h00, a});
		write_reg(REG_OBS_GAIN, {8'h00, h});
		write_reg(REG_PROCESS_NOISE, q);
		write_reg(REG_MEASURE_NOISE, r);
	endtask

	// Present one measurement request and hold it until the block takes it.
	// The caller lowers valid, so back-to-back requests keep it high.
	task automatic send_position(logic m, logic signed [23:0] x, logic signed [23:0] y);
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= m;
		pos_x <= x;
		pos_y <= y;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		tracker.note_request(m, x, y);
		sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Wait for every queued result, then a margin above the block's latency.
	task automatic drain();
		drop_valid();
		while (tracker.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	// Random position: mostly near a slowly drifting track, sometimes anywhere,
	// and now and then at a range edge so that saturation is reached.
	function automatic logic signed [23:0] pick_pos(logic signed [23:0] center);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			return center + $signed(24'($urandom_range(0, 4095))) - 24'sd2048;
		end else if (sel < 9) begin
			return 24'($urandom);
		end else begin
			return ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
		end
	endfunction

	// A random phase: bursts of requests with random gaps between them.
	task automatic random_phase(int count);
		logic signed [23:0] cx, cy;
		int                 burst;
		int                 done;
		cx = 24'($urandom);
		cy = 24'($urandom);
		done = 0;
		while (done < count) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && done < count; k++) begin
				cx = cx + $signed(24'($urandom_range(0, 511))) - 24'sd256;
				cy = cy + $signed(24'($urandom_range(0, 511))) - 24'sd256;
				send_position($urandom_range(0, 2) == 0, pick_pos(cx), pick_pos(cy));
				done++;
			end
			drop_valid();
			if ($urandom_range(0, 2) != 0) begin
				repeat ($urandom_range(0, 40)) @(negedge clk);
			end
		end
	endtask

	initial begin
		logic [15:0] a_val, h_val;
		logic [23:0] q_val, r_val;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part at reset settings: both modes, the edges of each field,
		// and a few steps toward a fixed point so the gain settles.
		stall_style = 0;
		send_position(1'b0, 24'sd0, 24'sd0);
		send_position(1'b1, 24'sh7FFFFF, 24'sh7FFFFF);
		send_position(1'b0, 24'sh800000, 24'sh7FFFFF);
		send_position(1'b1, 24'sh800000, 24'sh800000);
		send_position(1'b0, 24'sh7FFFFF, 24'sh800000);
		send_position(1'b0, -24'sd1, 24'sd1);
		send_position(1'b0, 24'sh555555, 24'shAAAAAA);
		send_position(1'b1, 24'shAAAAAA, 24'sh555555);
		for (int k = 0; k < 4; k++) begin
			send_position(1'b0, 24'sd2560, -24'sd2560);
		end
		drain();

		// Zero noise with zero gain factors makes the gain denominator zero.
		write_all(16'h0000, 16'h0000, 24'h000000, 24'h000000);
		send_position(1'b0, 24'sd1000, 24'sd1000);
		send_position(1'b1, 24'sh7FFFFF, 24'sh800000);
		drain();

		// Extreme factors and noise: most negative and most positive A and H,
		// largest Q and R, and zero R with nonzero H.
		write_all(16'h8000, 16'h8000, 24'hFFFFFF, 24'h000000);
		send_position(1'b0, 24'sh7FFFFF, 24'sh800000);
		send_position(1'b1, 24'sh800000, 24'sh7FFFFF);
		drain();
		write_all(16'h7FFF, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF);
		send_position(1'b0, 24'sh7FFFFF, 24'sh7FFFFF);
		send_position(1'b0, 24'sh800000, 24'sh800000);
		send_position(1'b1, 24'sd0, 24'sd0);
		drain();
		write_all(16'h1000, 16'hF000, 24'h000000, 24'h000001);
		send_position(1'b0, 24'sd300, -24'sd300);
		send_position(1'b0, -24'sd300, 24'sd300);
		drain();

		// Random phases, each with its own settings and receiver pattern.
		// Some use factors near one so the filter tracks; others go anywhere.
		for (int ph = 0; ph < 14; ph++) begin
			stall_style = ph % 4;
			case (ph % 5)
				0: begin
					a_val = 16'(4096 + $urandom_range(0, 256) - 128);
					h_val = 16'(4096 + $urandom_range(0, 256) - 128);
					q_val = 24'($urandom_range(0, 65535));
					r_val = 24'($urandom_range(0, 65535));
				end
				1: begin
					a_val = 16'($urandom);
					h_val = 16'($urandom);
					q_val = 24'($urandom);
					r_val = 24'($urandom);
				end
				2: begin
					a_val = 16'h1000;
					h_val = 16'($urandom_range(0, 1) != 0 ? 16'h1000 : 16'hF000);
					q_val = 24'($urandom_range(0, 16));
					r_val = 24'($urandom_range(0, 16));
				end
				3: begin
					a_val = 16'($urandom_range(0, 8191));
					h_val = 16'h0000;
					q_val = 24'($urandom_range(0, 3));
					r_val = 24'($urandom_range(0, 1));
				end
				default: begin
					a_val = 16'($urandom_range(3000, 5000));
					h_val = 16'($urandom_range(0, 65535));
					q_val = 24'hFFFFFF - 24'($urandom_range(0, 255));
					r_val = 24'($urandom_range(0, 1) != 0 ? 24'hFFFFFF : 24'h000000);
				end
			endcase
			write_all(a_val, h_val, q_val, r_val);
			random_phase(76);
			drain();
		end

		$display("Run covered %0d position requests and %0d checked results,",
			sent, tracker.checked);
		$display("with %0d zero-denominator steps over 19 register settings.",
			tracker.faults);
		if (tracker.errors == 0 && tracker.pending.size() == 0) begin
			$display("scalar_kalman_xy_tracker_tb passed");
		end else begin
			$display("%0d mismatches, %0d results still expected", tracker.errors,
				tracker.pending.size());
			$display("scalar_kalman_xy_tracker_tb failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
